/* sv/dfc_pkg.sv */
// Shared types and constants of the decision forest classifier.
// No dependencies; compiled first.
package dfc_pkg;

   localparam int NODE_COUNT_DEF    = 1024;
   localparam int MAX_TREES_DEF     = 64;
   localparam int FEATURE_COUNT_DEF = 64;
   localparam int CLASS_COUNT_DEF   = 16;
   localparam int DEPTH_LIMIT_DEF   = 16;

   localparam int OP_W        = 2;
   localparam int IDX_W       = 10;
   localparam int FEAT_W      = 6;
   localparam int THR_W       = 32;
   localparam int CHILD_W     = 10;
   localparam int CLS_W       = 4;
   localparam int VAL_W       = 32;
   localparam int TREE_CNT_W  = 7;
   localparam int CLASS_MAX_W = 4;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [OP_W-1:0] {
      OP_WR_NODE  = 2'd0,
      OP_WR_ROOT  = 2'd1,
      OP_WR_FEAT  = 2'd2,
      OP_CLASSIFY = 2'd3
   } op_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_TREE_COUNT = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLASS_MAX  = 4'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROOT,
      S_ROOTW,
      S_FEAT,
      S_CMP,
      S_SETTLE,
      S_SCAN,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [FEAT_W-1:0]       feat;
      logic signed [THR_W-1:0] thr;
      logic [CHILD_W-1:0]      lchild;
      logic                    lleaf;
      logic [CLS_W-1:0]        lcls;
      logic [CHILD_W-1:0]      rchild;
      logic                    rleaf;
      logic [CLS_W-1:0]        rcls;
   } node_type;

   typedef struct packed {
      logic node_wr;
      logic root_wr;
      logic feat_wr;
   } wr_cmd_type;

   typedef struct packed {
      logic node_rd;
      logic root_rd;
      logic feat_rd;
   } rd_cmd_type;

   typedef struct packed {
      logic clear;
      logic inc;
      logic scan;
   } tally_cmd_type;

endpackage

/* sv/dfc_if.sv */
// Handshake channels of the classifier: request, response and register write.
// Depends on dfc_pkg.
interface dfc_req_if;
   import dfc_pkg::*;
   logic                    valid;
   logic                    ready;
   op_type                  operation;
   logic [IDX_W-1:0]        index;
   logic [FEAT_W-1:0]       node_feature;
   logic signed [THR_W-1:0] node_threshold;
   logic [CHILD_W-1:0]      left_child;
   logic                    left_is_leaf;
   logic [CLS_W-1:0]        left_class;
   logic [CHILD_W-1:0]      right_child;
   logic                    right_is_leaf;
   logic [CLS_W-1:0]        right_class;
   logic signed [VAL_W-1:0] feature_value;

   modport source (
      output valid, operation, index, node_feature, node_threshold, left_child,
             left_is_leaf, left_class, right_child, right_is_leaf, right_class,
             feature_value,
      input  ready
   );
   modport sink (
      input  valid, operation, index, node_feature, node_threshold, left_child,
             left_is_leaf, left_class, right_child, right_is_leaf, right_class,
             feature_value,
      output ready
   );
endinterface

interface dfc_rsp_if;
   import dfc_pkg::*;
   logic             valid;
   logic             ready;
   logic [CLS_W-1:0] predicted_class;
   logic             path_too_deep;

   modport source (output valid, predicted_class, path_too_deep, input ready);
   modport sink   (input valid, predicted_class, path_too_deep, output ready);
endinterface

interface dfc_csr_if;
   import dfc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/decision_forest_classifier_top.sv */
// Write words (node, root, feature) are accepted in idle; ready stays high.
// Classify: each tree reads its root and then walks its levels; then the vote scan runs over classes
// 0..min(class_max,CLASS_COUNT-1) and the response is registered; ready is low until rsp valid, over any rsp stall.
// Each level is one node read, one feature read.
// Synchronous active-high reset: tree_count=1, class_max=1, no response pending; memories
// hold undefined data until written. Depends on dfc_pkg, dfc_if, dfc_mem, dfc_tally, dfc_ctrl.
module decision_forest_classifier_top #(
   parameter int NODE_COUNT    = dfc_pkg::NODE_COUNT_DEF,
   parameter int MAX_TREES     = dfc_pkg::MAX_TREES_DEF,
   parameter int FEATURE_COUNT = dfc_pkg::FEATURE_COUNT_DEF,
   parameter int CLASS_COUNT   = dfc_pkg::CLASS_COUNT_DEF,
   parameter int DEPTH_LIMIT   = dfc_pkg::DEPTH_LIMIT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dfc_csr_if.sink   csr_chan,
   dfc_req_if.sink   req_chan,
   dfc_rsp_if.source rsp_chan
);
   import dfc_pkg::*;

   localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int TW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
   localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
   localparam int CW = $clog2(CLASS_COUNT);

   wr_cmd_type         wr_cmd;
   rd_cmd_type         rd_cmd;
   node_type           wr_node;
   logic [NW-1:0]      node_addr;
   logic [TW-1:0]      root_addr;
   logic [FW-1:0]      feat_addr;
   node_type           node_q;
   logic [CHILD_W-1:0] root_q;
   logic [VAL_W-1:0]   feat_q;
   tally_cmd_type      tally_cmd;
   logic [CW-1:0]      tally_cls;
   logic [CW-1:0]      tally_top;
   logic               tally_done;
   logic [CW-1:0]      tally_best;

   always_comb begin
      wr_node.feat   = req_chan.node_feature;
      wr_node.thr    = req_chan.node_threshold;
      wr_node.lchild = req_chan.left_child;
      wr_node.lleaf  = req_chan.left_is_leaf;
      wr_node.lcls   = req_chan.left_class;
      wr_node.rchild = req_chan.right_child;
      wr_node.rleaf  = req_chan.right_is_leaf;
      wr_node.rcls   = req_chan.right_class;
   end

   dfc_ctrl #(
      .NODE_COUNT   (NODE_COUNT),
      .MAX_TREES    (MAX_TREES),
      .FEATURE_COUNT(FEATURE_COUNT),
      .CLASS_COUNT  (CLASS_COUNT),
      .DEPTH_LIMIT  (DEPTH_LIMIT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .wr_cmd    (wr_cmd),
      .rd_cmd    (rd_cmd),
      .node_addr (node_addr),
      .root_addr (root_addr),
      .feat_addr (feat_addr),
      .node_q    (node_q),
      .root_q    (root_q),
      .feat_q    (feat_q),
      .tally_cmd (tally_cmd),
      .tally_cls (tally_cls),
      .tally_top (tally_top),
      .tally_done(tally_done),
      .tally_best(tally_best)
   );

   dfc_mem #(
      .NODE_COUNT   (NODE_COUNT),
      .MAX_TREES    (MAX_TREES),
      .FEATURE_COUNT(FEATURE_COUNT)
   ) u_mem (
      .clock    (clock),
      .wr_cmd   (wr_cmd),
      .wr_index (req_chan.index),
      .wr_node  (wr_node),
      .wr_value (req_chan.feature_value),
      .rd_cmd   (rd_cmd),
      .node_addr(node_addr),
      .root_addr(root_addr),
      .feat_addr(feat_addr),
      .node_q   (node_q),
      .root_q   (root_q),
      .feat_q   (feat_q)
   );

   dfc_tally #(
      .CLASS_COUNT(CLASS_COUNT),
      .MAX_TREES  (MAX_TREES)
   ) u_tally (
      .clock(clock),
      .reset(reset),
      .cmd  (tally_cmd),
      .cls  (tally_cls),
      .top  (tally_top),
      .done (tally_done),
      .best (tally_best)
   );

endmodule

/* sv/dfc_mem.sv */
// Node, tree root and feature memories, one write and one registered read each.
// Depends on dfc_pkg.
module dfc_mem #(
   parameter int NODE_COUNT    = dfc_pkg::NODE_COUNT_DEF,
   parameter int MAX_TREES     = dfc_pkg::MAX_TREES_DEF,
   parameter int FEATURE_COUNT = dfc_pkg::FEATURE_COUNT_DEF,
   localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
   localparam int TW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1,
   localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1
) (
   input  logic                             clock,
   input  dfc_pkg::wr_cmd_type              wr_cmd,
   input  logic [dfc_pkg::IDX_W-1:0]        wr_index,
   input  dfc_pkg::node_type                wr_node,
   input  logic [dfc_pkg::VAL_W-1:0]        wr_value,
   input  dfc_pkg::rd_cmd_type              rd_cmd,
   input  logic [NW-1:0]                    node_addr,
   input  logic [TW-1:0]                    root_addr,
   input  logic [FW-1:0]                    feat_addr,
   output dfc_pkg::node_type                node_q,
   output logic [dfc_pkg::CHILD_W-1:0]      root_q,
   output logic [dfc_pkg::VAL_W-1:0]        feat_q
);
   import dfc_pkg::*;

   node_type           node_mem [NODE_COUNT];
   logic [CHILD_W-1:0] root_mem [MAX_TREES];
   logic [VAL_W-1:0]   feat_mem [FEATURE_COUNT];

   node_type           node_q_ff;
   logic [CHILD_W-1:0] root_q_ff;
   logic [VAL_W-1:0]   feat_q_ff;

   always_ff @(posedge clock) begin
      if (wr_cmd.node_wr) begin
         node_mem[NW'(wr_index)] <= wr_node;
      end
      if (rd_cmd.node_rd) begin
         node_q_ff <= node_mem[node_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.root_wr) begin
         root_mem[TW'(wr_index)] <= wr_value[CHILD_W-1:0];
      end
      if (rd_cmd.root_rd) begin
         root_q_ff <= root_mem[root_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.feat_wr) begin
         feat_mem[FW'(wr_index)] <= wr_value;
      end
      if (rd_cmd.feat_rd) begin
         feat_q_ff <= feat_mem[feat_addr];
      end
   end

   assign node_q = node_q_ff;
   assign root_q = root_q_ff;
   assign feat_q = feat_q_ff;

endmodule

/* sv/dfc_tally.sv */
// Vote counters: read-modify-write increment, per-class valid bits, argmax scan.
// Depends on dfc_pkg.
module dfc_tally #(
   parameter int CLASS_COUNT = dfc_pkg::CLASS_COUNT_DEF,
   parameter int MAX_TREES   = dfc_pkg::MAX_TREES_DEF,
   localparam int CW = $clog2(CLASS_COUNT),
   localparam int VW = $clog2(MAX_TREES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dfc_pkg::tally_cmd_type cmd,
   input  logic [CW-1:0]          cls,
   input  logic [CW-1:0]          top,
   output logic                   done,
   output logic [CW-1:0]          best
);
   import dfc_pkg::*;

   logic [VW-1:0] cnt_mem [CLASS_COUNT];
   logic [CLASS_COUNT-1:0] vld_ff;

   logic [VW-1:0] rd_cnt_ff;
   logic          rd_vld_ff;
   logic          inc_pend_ff;
   logic [CW-1:0] inc_addr_ff;
   logic          scan_on_ff;
   logic [CW-1:0] scan_ff;
   logic          cmp_on_ff;
   logic          cmp_last_ff;
   logic [CW-1:0] cmp_addr_ff;
   logic [CW-1:0] best_ff;
   logic [VW-1:0] bestv_ff;
   logic          done_ff;

   logic          rd_en;
   logic [CW-1:0] rd_addr;
   logic [VW-1:0] entry;
   logic          scan_last;

   assign rd_en     = cmd.inc || scan_on_ff;
   assign rd_addr   = scan_on_ff ? scan_ff : cls;
   assign entry     = rd_vld_ff ? rd_cnt_ff : '0;
   assign scan_last = (scan_ff == top);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_cnt_ff <= cnt_mem[rd_addr];
      end
      if (inc_pend_ff) begin
         cnt_mem[inc_addr_ff] <= entry + VW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_vld_ff <= vld_ff[rd_addr];
      end
      inc_addr_ff <= cls;
      cmp_addr_ff <= scan_ff;
      if (cmd.scan) begin
         best_ff  <= '0;
         bestv_ff <= '0;
      end else if (cmp_on_ff && (entry > bestv_ff)) begin
         best_ff  <= cmp_addr_ff;
         bestv_ff <= entry;
      end
      if (cmd.scan) begin
         scan_ff <= '0;
      end else if (scan_on_ff) begin
         scan_ff <= scan_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         inc_pend_ff <= 1'b0;
         scan_on_ff  <= 1'b0;
         cmp_on_ff   <= 1'b0;
         cmp_last_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         if (cmd.clear) begin
            vld_ff <= '0;
         end else if (inc_pend_ff) begin
            vld_ff[inc_addr_ff] <= 1'b1;
         end
         inc_pend_ff <= cmd.inc;
         if (cmd.scan) begin
            scan_on_ff <= 1'b1;
         end else if (scan_on_ff && scan_last) begin
            scan_on_ff <= 1'b0;
         end
         cmp_on_ff   <= scan_on_ff;
         cmp_last_ff <= scan_on_ff && scan_last;
         done_ff     <= cmp_on_ff && cmp_last_ff;
      end
   end

   assign done = done_ff;
   assign best = best_ff;

endmodule

/* sv/dfc_ctrl.sv */
// Sequencer of the classifier: register file, tree walk with the shared
// threshold comparator, depth count and the response register. Depends on dfc_pkg.
module dfc_ctrl #(
   parameter int NODE_COUNT    = dfc_pkg::NODE_COUNT_DEF,
   parameter int MAX_TREES     = dfc_pkg::MAX_TREES_DEF,
   parameter int FEATURE_COUNT = dfc_pkg::FEATURE_COUNT_DEF,
   parameter int CLASS_COUNT   = dfc_pkg::CLASS_COUNT_DEF,
   parameter int DEPTH_LIMIT   = dfc_pkg::DEPTH_LIMIT_DEF,
   localparam int NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
   localparam int TW  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1,
   localparam int FW  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1,
   localparam int CW  = $clog2(CLASS_COUNT)
) (
   input  logic                        clock,
   input  logic                        reset,
   dfc_csr_if.sink                     csr_chan,
   dfc_req_if.sink                     req_chan,
   dfc_rsp_if.source                   rsp_chan,
   output dfc_pkg::wr_cmd_type         wr_cmd,
   output dfc_pkg::rd_cmd_type         rd_cmd,
   output logic [NW-1:0]               node_addr,
   output logic [TW-1:0]               root_addr,
   output logic [FW-1:0]               feat_addr,
   input  dfc_pkg::node_type           node_q,
   input  logic [dfc_pkg::CHILD_W-1:0] root_q,
   input  logic [dfc_pkg::VAL_W-1:0]   feat_q,
   output dfc_pkg::tally_cmd_type      tally_cmd,
   output logic [CW-1:0]               tally_cls,
   output logic [CW-1:0]               tally_top,
   input  logic                        tally_done,
   input  logic [CW-1:0]               tally_best
);
   import dfc_pkg::*;

   localparam int TNW = $clog2(MAX_TREES + 1);
   localparam int DW  = $clog2(DEPTH_LIMIT + 1);

   state_type              state_ff, state_in;
   logic [TREE_CNT_W-1:0]  tree_count_ff;
   logic [CLASS_MAX_W-1:0] class_max_ff;
   logic [TNW-1:0]         tree_ff;
   logic [DW-1:0]          depth_ff;
   logic                   noor_ff;
   logic                   foor_ff;
   logic                   deep_ff;
   logic                   rsp_valid_ff;
   logic [CLS_W-1:0]       rsp_class_ff;
   logic                   rsp_deep_ff;

   logic                    req_acc;
   logic                    start;
   node_type                node_eff;
   logic signed [VAL_W-1:0] fval;
   logic                    go_left;
   logic                    leaf;
   logic [CLS_W-1:0]        cls;
   logic [CHILD_W-1:0]      child;
   logic [CHILD_W-1:0]      node_sel;
   logic [DW-1:0]           depth_nxt;
   logic                    depth_hit;
   logic                    end_tree;
   logic [TNW-1:0]          tree_nxt;
   logic                    more_trees;
   logic                    cls_ok;
   logic                    emit_go;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign start    = req_acc && (req_chan.operation == OP_CLASSIFY);

   // shared comparator: one node test per visit
   assign node_eff = noor_ff ? '0 : node_q;
   assign fval     = foor_ff ? '0 : $signed(feat_q);
   assign go_left  = fval < node_eff.thr;
   assign leaf     = go_left ? node_eff.lleaf : node_eff.rleaf;
   assign cls      = go_left ? node_eff.lcls : node_eff.rcls;
   assign child    = go_left ? node_eff.lchild : node_eff.rchild;

   assign node_sel   = (state_ff == S_ROOTW) ? root_q : child;
   assign depth_nxt  = depth_ff + DW'(1);
   assign depth_hit  = (32'(depth_nxt) == DEPTH_LIMIT);
   assign end_tree   = leaf || depth_hit;
   assign tree_nxt   = tree_ff + TNW'(1);
   assign more_trees = (32'(tree_nxt) < 32'(tree_count_ff)) && (32'(tree_nxt) < MAX_TREES);
   assign tally_top  = (32'(class_max_ff) > CLASS_COUNT - 1) ? CW'(CLASS_COUNT - 1)
                                                             : CW'(class_max_ff);
   assign cls_ok     = 32'(cls) <= 32'(tally_top);
   assign tally_cls  = CW'(cls);
   assign emit_go    = !rsp_valid_ff || rsp_chan.ready;

   assign node_addr  = NW'(node_sel);
   assign root_addr  = tree_ff[TW-1:0];
   assign feat_addr  = FW'(node_eff.feat);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (tree_count_ff == '0) ? S_SETTLE : S_ROOT;
            end
         end
         S_ROOT:  state_in = S_ROOTW;
         S_ROOTW: state_in = S_FEAT;
         S_FEAT:  state_in = S_CMP;
         S_CMP: begin
            if (!end_tree) begin
               state_in = S_FEAT;
            end else if (more_trees) begin
               state_in = S_ROOT;
            end else begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: state_in = S_SCAN;
         S_SCAN: begin
            if (tally_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready  = (state_ff == S_IDLE);
      wr_cmd.node_wr  = req_acc && (req_chan.operation == OP_WR_NODE)
                        && (32'(req_chan.index) < NODE_COUNT);
      wr_cmd.root_wr  = req_acc && (req_chan.operation == OP_WR_ROOT)
                        && (32'(req_chan.index) < MAX_TREES);
      wr_cmd.feat_wr  = req_acc && (req_chan.operation == OP_WR_FEAT)
                        && (32'(req_chan.index) < FEATURE_COUNT);
      rd_cmd.root_rd  = (state_ff == S_ROOT);
      rd_cmd.node_rd  = (state_ff == S_ROOTW) || ((state_ff == S_CMP) && !end_tree);
      rd_cmd.feat_rd  = (state_ff == S_FEAT);
      tally_cmd.clear = start;
      tally_cmd.inc   = (state_ff == S_CMP) && leaf && cls_ok;
      tally_cmd.scan  = (state_ff == S_SETTLE);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         tree_ff <= '0;
      end else if ((state_ff == S_CMP) && end_tree) begin
         tree_ff <= tree_nxt;
      end
      if (state_ff == S_ROOTW) begin
         depth_ff <= '0;
      end else if (state_ff == S_CMP) begin
         depth_ff <= depth_nxt;
      end
      if (rd_cmd.node_rd) begin
         noor_ff <= (32'(node_sel) >= NODE_COUNT);
      end
      if (rd_cmd.feat_rd) begin
         foor_ff <= (32'(node_eff.feat) >= FEATURE_COUNT);
      end
      if (start) begin
         deep_ff <= 1'b0;
      end else if ((state_ff == S_CMP) && !leaf && depth_hit) begin
         deep_ff <= 1'b1;
      end
      if ((state_ff == S_EMIT) && emit_go) begin
         rsp_class_ff <= CLS_W'(tally_best);
         rsp_deep_ff  <= deep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tree_count_ff <= TREE_CNT_W'(1);
         class_max_ff  <= CLASS_MAX_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_TREE_COUNT: tree_count_ff <= csr_chan.data[TREE_CNT_W-1:0];
               CSR_CLASS_MAX:  class_max_ff  <= csr_chan.data[CLASS_MAX_W-1:0];
               default: ;
            endcase
         end
         if ((state_ff == S_EMIT) && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.predicted_class = rsp_class_ff;
   assign rsp_chan.path_too_deep  = rsp_deep_ff;

endmodule

/* sv/dfc_checker.sv */
// Port-level checks of the classifier top, attached by bind.
// Depends on dfc_pkg and decision_forest_classifier_top.
module dfc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [dfc_pkg::OP_W-1:0]  req_operation,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [dfc_pkg::CLS_W-1:0] rsp_predicted_class,
   input logic                      rsp_path_too_deep
);
   import dfc_pkg::*;

   logic req_acc;
   logic is_classify;

   assign req_acc     = req_valid && req_ready;
   assign is_classify = (req_operation == OP_CLASSIFY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_predicted_class)
                                  && $stable(rsp_path_too_deep))
      else $error("response word changed while stalled");

   a_busy_after_classify: assert property (@(posedge clock) disable iff (reset)
      req_acc && is_classify |=> !req_ready)
      else $error("request ready right after classify word");

   a_write_single_cycle: assert property (@(posedge clock) disable iff (reset)
      req_acc && !is_classify |=> req_ready)
      else $error("write word did not complete in one cycle");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a classify in progress");

endmodule

bind decision_forest_classifier_top dfc_checker u_dfc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_operation      (req_chan.operation),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_predicted_class(rsp_chan.predicted_class),
   .rsp_path_too_deep  (rsp_chan.path_too_deep)
);
